// File: design/rgb_crp_pkg.sv
// Package for the rgb colour reply parser: item types and prefix characters.
package rgb_crp_pkg;

	// One byte of reply text and its end marker.
	typedef struct packed {
		logic [7:0] reply_byte;
		logic       last_byte;
	} req_item_t;

	// Parsed colour and its status.
	typedef struct packed {
		logic [23:0] color_word;
		logic        parse_ok;
	} rsp_item_t;

	localparam logic [7:0] PREFIX_R     = 8'h72; // 'r'
	localparam logic [7:0] PREFIX_G     = 8'h67; // 'g'
	localparam logic [7:0] PREFIX_B     = 8'h62; // 'b'
	localparam logic [7:0] PREFIX_COLON = 8'h3A; // ':'
	localparam logic [7:0] FIELD_SEP    = 8'h2F; // '/'
	localparam logic [7:0] TEXT_END     = 8'h00;

endpackage

// File: design/rgb_color_reply_parser.sv
// Top level of the rgb colour reply parser: byte input stage, parse logic, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  req     | in        | req_valid/req_stall  | req_item : reply_byte, last_byte
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_item : color_word, parse_ok
//
// One byte item is taken every cycle while req_stall is low. An item waits in the
// input register, then the parse state is updated from it; a last byte also loads
// the result register from the input register, unless a held result stalls that
// last byte there.
// Reset (arst_n low) returns the parser to the prefix search and empties both
// registers. A result held by rsp_stall does not block bytes that are not
// last; only a second last byte waits in the input register, and req_stall
// rises while it does.
module rgb_color_reply_parser #(
	parameter int MAX_DIGITS = 4
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  rgb_crp_pkg::req_item_t req_item,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output rgb_crp_pkg::rsp_item_t rsp_item
);

	localparam int CntW = $clog2(MAX_DIGITS + 1);

	typedef enum logic [2:0] {
		PH_SEARCH = 3'd0,
		PH_RED    = 3'd1,
		PH_GREEN  = 3'd2,
		PH_BLUE   = 3'd3,
		PH_DONE   = 3'd4,
		PH_FAIL   = 3'd5
	} phase_t;

	// hex digit decode: bit 4 flags a valid digit
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	// input register
	logic                   valid_s1;
	rgb_crp_pkg::req_item_t item_s1;

	// parse state
	phase_t            phase_q;
	logic [1:0]        matched_q;
	logic [CntW-1:0]   count_q;
	logic [7:0]        top_q;
	logic [7:0]        red_q;
	logic [7:0]        green_q;
	logic              ended_q;

	// next state
	phase_t            phase_d;
	logic [1:0]        matched_d;
	logic [CntW-1:0]   count_d;
	logic [7:0]        top_d;
	logic [7:0]        red_d;
	logic [7:0]        green_d;
	logic              ended_d;
	logic              ok_d;
	logic [4:0]        hex;

	logic advance;

	// a last byte can only move on when the result register is free
	assign advance   = valid_s1 && !(item_s1.last_byte && rsp_valid && rsp_stall);
	assign req_stall = valid_s1 && !advance;

	always_comb begin
		logic [7:0] c;
		logic [7:0] want;
		c         = item_s1.reply_byte;
		phase_d   = phase_q;
		matched_d = matched_q;
		count_d   = count_q;
		top_d     = top_q;
		red_d     = red_q;
		green_d   = green_q;
		ended_d   = ended_q;
		hex       = hex_decode(c);
		unique case (matched_q)
			2'd0: want = rgb_crp_pkg::PREFIX_R;
			2'd1: want = rgb_crp_pkg::PREFIX_G;
			2'd2: want = rgb_crp_pkg::PREFIX_B;
			2'd3: want = rgb_crp_pkg::PREFIX_COLON;
			default: want = rgb_crp_pkg::PREFIX_R;
		endcase
		if (!ended_q) begin
			if (c == rgb_crp_pkg::TEXT_END) begin
				ended_d = 1'b1;
			end else if (phase_q == PH_SEARCH) begin
				if (c == want) begin
					if (matched_q == 2'd3) begin
						matched_d = 2'd0;
						phase_d   = PH_RED;
						count_d   = '0;
						top_d     = 8'd0;
					end else begin
						matched_d = matched_q + 2'd1;
					end
				end else begin
					// the prefix does not overlap itself; only 'r' restarts it
					matched_d = (c == rgb_crp_pkg::PREFIX_R) ? 2'd1 : 2'd0;
				end
			end else if (phase_q == PH_RED || phase_q == PH_GREEN || phase_q == PH_BLUE) begin
				if (hex[4]) begin
					if (count_q >= CntW'(MAX_DIGITS)) begin
						phase_d = PH_FAIL;
					end else begin
						if (count_q == '0)
							top_d = {hex[3:0], 4'd0};
						else if (count_q == CntW'(1))
							top_d = {top_q[7:4], hex[3:0]};
						count_d = count_q + CntW'(1);
					end
				end else if (count_q == '0) begin
					phase_d = PH_FAIL;
				end else if (phase_q == PH_BLUE) begin
					phase_d = PH_DONE;
				end else if (c != rgb_crp_pkg::FIELD_SEP) begin
					phase_d = PH_FAIL;
				end else begin
					if (phase_q == PH_RED) begin
						red_d   = top_q;
						phase_d = PH_GREEN;
					end else begin
						green_d = top_q;
						phase_d = PH_BLUE;
					end
					count_d = '0;
					top_d   = 8'd0;
				end
			end
		end
		ok_d = (phase_d == PH_DONE) || (phase_d == PH_BLUE && count_d != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			item_s1   <= '0;
			rsp_valid <= 1'b0;
			rsp_item  <= '0;
			phase_q   <= PH_SEARCH;
			matched_q <= 2'd0;
			count_q   <= '0;
			top_q     <= 8'd0;
			red_q     <= 8'd0;
			green_q   <= 8'd0;
			ended_q   <= 1'b0;
		end else begin
			if (req_valid && !req_stall) begin
				valid_s1 <= 1'b1;
				item_s1  <= req_item;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end

			if (advance && item_s1.last_byte) begin
				rsp_valid           <= 1'b1;
				rsp_item.parse_ok   <= ok_d;
				rsp_item.color_word <= ok_d ? {red_d, green_d, top_d} : 24'd0;
				// back to the prefix search for the next reply
				phase_q   <= PH_SEARCH;
				matched_q <= 2'd0;
				count_q   <= '0;
				top_q     <= 8'd0;
				red_q     <= 8'd0;
				green_q   <= 8'd0;
				ended_q   <= 1'b0;
			end else begin
				if (!rsp_stall)
					rsp_valid <= 1'b0;
				if (advance) begin
					phase_q   <= phase_d;
					matched_q <= matched_d;
					count_q   <= count_d;
					top_q     <= top_d;
					red_q     <= red_d;
					green_q   <= green_d;
					ended_q   <= ended_d;
				end
			end
		end
	end

endmodule

// File: design/rgb_crp_checker.sv
// Port checker for the rgb colour reply parser, with its bind.
module rgb_crp_assertions (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_stall,
	input rgb_crp_pkg::req_item_t req_item,
	input logic                   rsp_valid,
	input logic                   rsp_stall,
	input rgb_crp_pkg::rsp_item_t rsp_item
);

	// stalled input item stays put
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req_item))
		else $error("input item changed while stalled");

	// held result stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
		else $error("result changed while stalled");

	// a failed reply carries no colour
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_item.parse_ok |-> rsp_item.color_word == 24'd0)
		else $error("colour set on failed reply");

	// input only backs up behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("input stalled without held result");

	// a waiting last byte always has a result in front of it or gets one
	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |=> rsp_valid)
		else $error("held last byte gave no result");

endmodule

bind rgb_color_reply_parser rgb_crp_assertions u_rgb_crp_assertions (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req_item  (req_item),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp_item  (rsp_item)
);
